// ===== rtl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB package
// Segment codes for the per-channel hue ramp and the stage load enables that
// the top level hands to each channel slice.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  // Which piece of the hue ramp a channel falls on.
  typedef logic [1:0] seg_t;

  localparam seg_t SEG_RISE = 2'd0;  // below one sixth: ramp from lo up to hi
  localparam seg_t SEG_HOLD = 2'd1;  // one sixth up to one half: flat at hi
  localparam seg_t SEG_FALL = 2'd2;  // one half up to two thirds: ramp down
  localparam seg_t SEG_LOW  = 2'd3;  // two thirds and above: flat at lo

  // Load enables for pipeline stages two to four.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// ===== rtl/hsl2rgb_chan.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB channel slice
// Turns one channel hue into an 8-bit color value over pipeline stages two
// to four: ramp segment and slope factor, ramp product, then scale by 255.
// ----------------------------------------------------------------------------
module hsl2rgb_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  hsl2rgb_pkg::pipe_en_t  en,
  input  logic [FRAC_BITS:0]     hue_t,    // stage one: channel hue
  input  logic [FRAC_BITS:0]     span,     // stage two: hi minus lo
  input  logic [FRAC_BITS:0]     level_hi, // stage three
  input  logic [FRAC_BITS:0]     level_lo, // stage three
  output logic [7:0]             value     // stage four
);
  import hsl2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam logic [W-1:0] SIXTH      = W'(ONE / 6);
  localparam logic [W-1:0] HALF       = W'(ONE / 2);
  localparam logic [W-1:0] TWO_THIRDS = W'((2 * ONE) / 3);

  logic [W-1:0]   fall_gap;
  logic [W+2:0]   six_t;
  logic [W+2:0]   six_gap;
  seg_t           seg_next;
  logic [W-1:0]   slope_next;
  seg_t           seg2;
  logic [W-1:0]   slope2;
  logic [2*W-1:0] prod;
  seg_t           seg3;
  logic [W:0]     ramp3;
  logic [W:0]     level;
  logic [W+8:0]   scaled;
  logic [9:0]     scaled_int;
  logic [7:0]     value_next;

  // Stage two: pick the ramp segment and form six times the distance to the ramp's lo end.
  always_comb begin
    fall_gap = TWO_THIRDS - hue_t;
    six_t    = {1'b0, hue_t, 2'b00} + {2'b00, hue_t, 1'b0};
    six_gap  = {1'b0, fall_gap, 2'b00} + {2'b00, fall_gap, 1'b0};
    if (hue_t < SIXTH) begin
      seg_next = SEG_RISE;
    end else if (hue_t < HALF) begin
      seg_next = SEG_HOLD;
    end else if (hue_t < TWO_THIRDS) begin
      seg_next = SEG_FALL;
    end else begin
      seg_next = SEG_LOW;
    end
    slope_next = (seg_next == SEG_RISE) ? six_t[W-1:0] : six_gap[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      seg2   <= seg_next;
      slope2 <= slope_next;
    end
  end

  // Stage three: ramp product, truncated back to the fraction grid.
  assign prod = span * slope2;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      seg3  <= seg2;
      ramp3 <= prod[2*W-1:FRAC_BITS];
    end
  end

  // Stage four: select the channel level, scale by 255 and saturate.
  always_comb begin
    case (seg3)
      SEG_RISE: level = {1'b0, level_lo} + ramp3;
      SEG_HOLD: level = {1'b0, level_hi};
      SEG_FALL: level = {1'b0, level_lo} + ramp3;
      SEG_LOW:  level = {1'b0, level_lo};
      default:  level = {1'b0, level_lo};
    endcase
    scaled     = {level, 8'h00} - {8'h00, level};
    scaled_int = scaled[W+8:FRAC_BITS];
    value_next = (scaled_int > 10'd255) ? 8'hFF : scaled_int[7:0];
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      value <= value_next;
    end
  end

endmodule

// ===== rtl/hsl_to_rgb_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB pixel unit
// Converts one 8-bit hue, saturation, lightness and alpha pixel into 8-bit
// red, green and blue, computed in unsigned fixed point; alpha passes through.
//
//   Channel   Direction  Handshake          Payload
//   input     in         in_valid/in_ready  hue, saturation, lightness, alpha_in
//   output    out        out_valid/out_ready red, green, blue, alpha_out
//
// One pixel enters per clock unless a stall on the output holds the pipeline.
// Each pixel passes through four register stages: channel hues and the l*s
// product, the two levels, the ramp multiply, and the scale by 255.
// Reset clears the stage valid bits only; no pass is needed after reset.
// A stall holds the stages that are full and lets bubbles behind them fill.
// ----------------------------------------------------------------------------
module hsl_to_rgb_pixel_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] lightness,
  input  logic [7:0] alpha_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha_out
);
  import hsl2rgb_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int W = FRAC_BITS + 1;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam logic [W-1:0] ONE_W     = W'(ONE);
  localparam logic [W-1:0] THIRD     = W'(ONE / 3);
  localparam logic [W-1:0] CO_THIRD  = W'(ONE - ONE / 3);
  localparam logic [F-1:0] HALF      = F'(ONE / 2);

  // Stage valid bits and ready chain.
  logic     valid1, valid2, valid3, valid4;
  logic     rdy1, rdy2, rdy3, rdy4;
  pipe_en_t en;

  assign rdy4     = !valid4 || out_ready;
  assign rdy3     = !valid3 || rdy4;
  assign rdy2     = !valid2 || rdy3;
  assign rdy1     = !valid1 || rdy2;
  assign in_ready = rdy1;
  assign en.s2    = rdy2;
  assign en.s3    = rdy3;
  assign en.s4    = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (rdy1) valid1 <= in_valid;
      if (rdy2) valid2 <= valid1;
      if (rdy3) valid3 <= valid2;
      if (rdy4) valid4 <= valid3;
    end
  end

  assign out_valid = valid4;

  // Stage one: expand to fixed point, form the channel hues and l*s.
  logic [F-1:0]   hue_fx, sat_fx, light_fx;
  logic [2*F-1:0] ls_prod;
  logic [W-1:0]   tr_sum, tr_next, tb_next;
  logic [F-1:0]   light1, sat1, ls1;
  logic [W-1:0]   tr1, tg1, tb1;
  logic           grey1;
  logic [7:0]     alpha1, alpha2, alpha3, alpha4;

  always_comb begin
    hue_fx   = {hue, {(F-8){1'b0}}};
    sat_fx   = {saturation, {(F-8){1'b0}}};
    light_fx = {lightness, {(F-8){1'b0}}};
    ls_prod  = light_fx * sat_fx;
    tr_sum   = {1'b0, hue_fx} + THIRD;
    tr_next  = (tr_sum > ONE_W) ? tr_sum - ONE_W : tr_sum;
    tb_next  = ({1'b0, hue_fx} < THIRD) ? {1'b0, hue_fx} + CO_THIRD
                                         : {1'b0, hue_fx} - THIRD;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      light1 <= light_fx;
      sat1   <= sat_fx;
      ls1    <= ls_prod[2*F-1:F];
      tr1    <= tr_next;
      tg1    <= {1'b0, hue_fx};
      tb1    <= tb_next;
      grey1  <= (saturation == 8'h00);
      alpha1 <= alpha_in;
    end
  end

  // Stage two: the hi and lo levels and their difference. Grey pins both
  // levels to the lightness so every channel comes out equal to it.
  logic [F-1:0] excess;
  logic [W-1:0] hi_next, lo_next, span_next;
  logic [W-1:0] hi2, lo2, span2;
  logic [W-1:0] hi3, lo3;

  always_comb begin
    excess = (light1 < HALF) ? ls1 : sat1 - ls1;
    if (grey1) begin
      hi_next   = {1'b0, light1};
      lo_next   = {1'b0, light1};
      span_next = '0;
    end else begin
      hi_next = {1'b0, light1} + {1'b0, excess};
      if (light1 < excess) begin
        lo_next   = '0;
        span_next = hi_next;
      end else begin
        lo_next   = {1'b0, light1} - {1'b0, excess};
        span_next = {excess, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      hi2    <= hi_next;
      lo2    <= lo_next;
      span2  <= span_next;
      alpha2 <= alpha1;
    end
  end

  // Stage three carries the levels and alpha beside the channels; stage four alpha.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      hi3    <= hi2;
      lo3    <= lo2;
      alpha3 <= alpha2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      alpha4 <= alpha3;
    end
  end

  assign alpha_out = alpha4;

  // One slice per color channel.
  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk      (clk),
    .en       (en),
    .hue_t    (tr1),
    .span     (span2),
    .level_hi (hi3),
    .level_lo (lo3),
    .value    (red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk      (clk),
    .en       (en),
    .hue_t    (tg1),
    .span     (span2),
    .level_hi (hi3),
    .level_lo (lo3),
    .value    (green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk      (clk),
    .en       (en),
    .hue_t    (tb1),
    .span     (span2),
    .level_hi (hi3),
    .level_lo (lo3),
    .value    (blue)
  );

endmodule
